### src/vertical_complementary_altitude_filter_core_macros.svh
// Assertion macros shared by the altitude filter RTL.
`ifndef VERTICAL_COMPLEMENTARY_ALTITUDE_FILTER_CORE_MACROS_SVH
`define VERTICAL_COMPLEMENTARY_ALTITUDE_FILTER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property outside reset.
`define VCAF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("altitude filter assertion failed");
// Check a property at every edge, reset included.
`define VCAF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("altitude filter assertion failed");
`else
`define VCAF_ASSERT(lbl, clk, rst_n, prop)
`define VCAF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### src/vcaf_pkg.sv
// Types and constants of the vertical altitude filter.
package vcaf_pkg;
    localparam int unsigned VAL_W   = 48;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned TAP_W   = 6;
    localparam int unsigned CIDX_W  = 3;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [GAIN_W-1:0]       t_gain;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_DELAY_TAPS     = 3'd0;
    localparam logic [CIDX_W-1:0] REG_GAIN_ACCEL     = 3'd1;
    localparam logic [CIDX_W-1:0] REG_GAIN_SPEED     = 3'd2;
    localparam logic [CIDX_W-1:0] REG_GAIN_POSITION  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_FAIL_THRESHOLD = 3'd4;

    // Reset values of the registers.
    localparam logic [TAP_W-1:0] RST_DELAY_TAPS     = 6'd20;
    localparam t_gain            RST_GAIN_ACCEL     = 16'd1529;
    localparam t_gain            RST_GAIN_SPEED     = 16'd16050;
    localparam t_gain            RST_GAIN_POSITION  = 16'd56174;
    localparam t_gain            RST_FAIL_THRESHOLD = 16'd10;

    // Command from the sequencer to the position history.
    typedef struct packed {
        logic wr;
        logic reseed;
        t_val data;
    } t_hist_cmd;
endpackage

### src/vcaf_mul.sv
// Shared registered multiplier: floor(a * g / 2^16) of a signed value and a Q0.16 factor.
module vcaf_mul
    import vcaf_pkg::*;
(
    input  logic  i_clk,
    input  t_val  i_a,
    input  t_gain i_g,
    output t_val  o_p
);
    logic signed [VAL_W+GAIN_W:0] w_prod;
    t_val r_p;

    // The arithmetic shift of the full product rounds toward minus infinity.
    assign w_prod = i_a * $signed({1'b0, i_g});

    always_ff @(posedge i_clk) begin
        r_p <= w_prod[VAL_W+GAIN_W-1:GAIN_W];
    end

    assign o_p = r_p;
endmodule

### src/vcaf_hist.sv
// Circular delay line of fused positions with a fill count and a reseed value.
module vcaf_hist
    import vcaf_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_hist_cmd        i_cmd,
    input  logic [TAP_W-1:0] i_taps,
    output t_val             o_val
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned XW = (CW > TAP_W) ? CW : TAP_W;
    localparam logic [XW-1:0] LAST = XW'(DEPTH - 1);

    t_val             r_mem [DEPTH];
    t_val             r_rd;
    t_val             r_base;
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rd_addr;
    logic [CW-1:0]    r_cnt;
    logic             r_use_base;
    logic [XW-1:0]    w_tap_x;
    logic [AW-1:0]    w_tap;
    logic [CW-1:0]    n_cnt;

    // Delays past the end of the line stop at the oldest entry.
    assign w_tap_x = (XW'(i_taps) > LAST) ? LAST : XW'(i_taps);
    assign w_tap   = w_tap_x[AW-1:0];

    // Entries written since the last reseed, saturating at the depth.
    always_comb begin
        if (i_cmd.reseed) begin
            n_cnt = CW'(1);
        end else if (r_cnt == CW'(DEPTH)) begin
            n_cnt = r_cnt;
        end else begin
            n_cnt = r_cnt + CW'(1);
        end
    end

    // Pointer, count and reseed value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_cnt  <= '0;
            r_base <= '0;
        end else if (i_cmd.wr) begin
            r_wp  <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            r_cnt <= n_cnt;
            if (i_cmd.reseed) begin
                r_base <= i_cmd.data;
            end
        end
    end

    // Read address and whether the tap lies before the last reseed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_rd_addr  <= (r_wp >= w_tap) ? r_wp - w_tap : r_wp + AW'(DEPTH) - w_tap;
            r_use_base <= !(XW'(w_tap) < XW'(n_cnt));
        end
    end

    // Memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[r_wp] <= i_cmd.data;
        end
        r_rd <= r_mem[r_rd_addr];
    end

    assign o_val = r_use_base ? r_base : r_rd;
endmodule

### src/vertical_complementary_altitude_filter_core.sv
// Top level of the vertical third-order complementary altitude filter.
// Input channel (i_s_*): one item per tick with acceleration, observation and tick length.
// Output channel (o_m_*): one item per input item with fused position, speed,
// acceleration and a fail flag. Configuration channel (i_cfg_*): register writes,
// always ready, to be used only while the filter is idle.
// From acceptance to the result an item passes a load step, a history read,
// the error, eight products through the single shared 48x16 multiplier, each a
// multiply and an apply step, and the final steps that form the fused outputs.
// A new item is accepted only in the idle state, so each item is finished
// before the next one is taken.
// The result waits in an output register; a stalled receiver holds the block
// at the end of the next item until the waiting result is taken.
// Reset clears all filter state and the history to zero, loads the register
// defaults, and needs no clearing pass: the history reads the reseed value
// for entries not yet written.
`include "vertical_complementary_altitude_filter_core_macros.svh"
module vertical_complementary_altitude_filter_core
    import vcaf_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = 64
)(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // raw_accel[47:0], observed_altitude[95:48], delta_time[111:96]
    input  logic [111:0]        i_s_tdata,
    // observation_valid[0], source_switched[1]
    input  logic [1:0]          i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // fused_position[47:0], fused_speed[95:48], fused_accel[143:96]
    output logic [143:0]        o_m_tdata,
    // fusion_fail[0]
    output logic                o_m_tuser,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [GAIN_W-1:0]   i_cfg_data
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_ERR   = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_APPLY = 8'b0010_0000,
        S_FIN1  = 8'b0100_0000,
        S_FIN2  = 8'b1000_0000
    } t_state;

    // Steps of the product sequence.
    localparam logic [2:0] OP_ERR_GA = 3'd0;
    localparam logic [2:0] OP_ACC_DT = 3'd1;
    localparam logic [2:0] OP_ERR_GS = 3'd2;
    localparam logic [2:0] OP_SPD_DT = 3'd3;
    localparam logic [2:0] OP_ERR_GP = 3'd4;
    localparam logic [2:0] OP_POS_DT = 3'd5;
    localparam logic [2:0] OP_DV     = 3'd6;
    localparam logic [2:0] OP_INNER  = 3'd7;

    t_state r_state;
    logic [2:0] r_op;

    logic [TAP_W-1:0] r_taps;
    t_gain r_ga, r_gs, r_gp, r_thr;

    t_val  r_raw, r_obs, r_held, r_err, r_t;
    t_gain r_dt;
    logic  r_obsv, r_sw;
    t_val  r_ca, r_cs, r_cpc, r_up, r_us, r_cp, r_csp, r_cacc, r_prev;

    logic  r_ovalid;
    t_val  r_opos, r_ospd, r_oacc;
    logic  r_ofail;

    t_val      n_held;
    t_hist_cmd w_cmd;
    t_val      w_hist;
    t_val      w_mul_a, w_mul_p;
    t_gain     w_mul_g;
    logic signed [VAL_W:0] w_sum;
    logic signed [VAL_W:0] w_diff;
    logic [VAL_W:0]        w_mag;
    logic                  w_in_acc, w_out_load;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_out_load  = (r_state == S_FIN2) && (!r_ovalid || i_m_tready);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= RST_DELAY_TAPS;
            r_ga   <= RST_GAIN_ACCEL;
            r_gs   <= RST_GAIN_SPEED;
            r_gp   <= RST_GAIN_POSITION;
            r_thr  <= RST_FAIL_THRESHOLD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DELAY_TAPS:     r_taps <= i_cfg_data[TAP_W-1:0];
                REG_GAIN_ACCEL:     r_ga   <= i_cfg_data;
                REG_GAIN_SPEED:     r_gs   <= i_cfg_data;
                REG_GAIN_POSITION:  r_gp   <= i_cfg_data;
                REG_FAIL_THRESHOLD: r_thr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Observation that holds for this tick.
    assign n_held = r_obsv ? r_obs : r_held;

    // History write: the current fused position, or the observation on reseed.
    assign w_cmd.wr     = (r_state == S_LOAD);
    assign w_cmd.reseed = r_sw;
    assign w_cmd.data   = r_sw ? n_held : r_cp;

    vcaf_hist #(.DEPTH(HISTORY_DEPTH)) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_taps  (r_taps),
        .o_val   (w_hist)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_op) inside
            OP_ERR_GA, OP_ERR_GS, OP_ERR_GP: w_mul_a = r_err;
            default:                         w_mul_a = r_t;
        endcase
        case (r_op)
            OP_ERR_GA: w_mul_g = r_ga;
            OP_ERR_GS: w_mul_g = r_gs;
            OP_ERR_GP: w_mul_g = r_gp;
            default:   w_mul_g = r_dt;
        endcase
    end

    vcaf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_g   (w_mul_g),
        .o_p   (w_mul_p)
    );

    // Mean of the previous and current acceleration, before halving.
    assign w_sum = {r_prev[VAL_W-1], r_prev} + {r_cacc[VAL_W-1], r_cacc};

    // Exact distance between fused position and observation.
    assign w_diff = {r_cp[VAL_W-1], r_cp} - {r_held[VAL_W-1], r_held};
    assign w_mag  = w_diff[VAL_W] ? (VAL_W+1)'(-w_diff) : (VAL_W+1)'(w_diff);

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_ERR_GA;
        end else begin
            unique case (r_state)
                S_IDLE:  if (w_in_acc) r_state <= S_LOAD;
                S_LOAD:  r_state <= S_READ;
                S_READ:  r_state <= S_ERR;
                S_ERR: begin
                    r_op    <= OP_ERR_GA;
                    r_state <= S_MUL;
                end
                S_MUL:   r_state <= S_APPLY;
                S_APPLY: begin
                    if (r_op == OP_INNER) begin
                        r_state <= S_FIN1;
                    end else begin
                        r_op    <= r_op + 3'd1;
                        r_state <= S_MUL;
                    end
                end
                S_FIN1:  r_state <= S_FIN2;
                S_FIN2:  if (w_out_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_ca   <= '0;
            r_cs   <= '0;
            r_cpc  <= '0;
            r_up   <= '0;
            r_us   <= '0;
            r_cp   <= '0;
            r_csp  <= '0;
            r_cacc <= '0;
            r_prev <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    r_held <= n_held;
                    if (r_sw) begin
                        r_cp  <= n_held;
                        r_up  <= n_held;
                        r_us  <= '0;
                        r_ca  <= '0;
                        r_cs  <= '0;
                        r_cpc <= '0;
                    end
                end
                S_APPLY: begin
                    case (r_op)
                        OP_ACC_DT: r_ca <= r_ca + w_mul_p;
                        OP_SPD_DT: begin
                            r_cs   <= r_cs + w_mul_p;
                            r_prev <= r_cacc;
                            r_cacc <= r_raw + r_ca;
                        end
                        OP_POS_DT: r_cpc <= r_cpc + w_mul_p;
                        OP_DV:     r_us  <= r_us + w_mul_p;
                        OP_INNER:  r_up  <= r_up + w_mul_p;
                        default: ;
                    endcase
                end
                S_FIN1: begin
                    r_cp  <= r_up + r_cpc;
                    r_csp <= r_us + r_cs;
                end
                default: ;
            endcase
        end
    end

    // Item payload, error and intermediate product.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_raw  <= i_s_tdata[47:0];
            r_obs  <= i_s_tdata[95:48];
            r_dt   <= i_s_tdata[111:96];
            r_obsv <= i_s_tuser[0];
            r_sw   <= i_s_tuser[1];
        end
        if (r_state == S_ERR) begin
            r_err <= r_held - w_hist;
        end
        if (r_state == S_APPLY) begin
            case (r_op) inside
                OP_ERR_GA, OP_ERR_GS, OP_ERR_GP: r_t <= w_mul_p;
                OP_POS_DT: r_t <= w_sum[VAL_W:1];
                OP_DV:     r_t <= r_csp + {w_mul_p[VAL_W-1], w_mul_p[VAL_W-1:1]};
                default: ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_opos  <= r_cp;
            r_ospd  <= r_csp;
            r_oacc  <= r_cacc;
            r_ofail <= (w_mag > {1'b0, r_thr, 32'd0} >> 16);
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {r_oacc, r_ospd, r_opos};
    assign o_m_tuser  = r_ofail;

    // Checks on the sequencer and the output register.
    `VCAF_ASSERT(a_accept_loads, i_clk, i_rst_n, w_in_acc |=> (r_state == S_LOAD))
    `VCAF_ASSERT(a_apply_after_mul, i_clk, i_rst_n, (r_state == S_APPLY) |-> ($past(r_state) == S_MUL))
    `VCAF_ASSERT(a_no_overwrite, i_clk, i_rst_n, (r_ovalid && !i_m_tready) |-> !w_out_load)
    `VCAF_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_tvalid)
endmodule
